[hdl/ebb_pkg.sv]
`default_nettype none

package ebb_pkg;

   localparam int PIXEL_W     = 24;
   localparam int CHAN_W      = 8;
   localparam int WIDTH_REG_W = 11;
   localparam int HEIGHT_W    = 16;
   localparam int IN_ROW_W    = HEIGHT_W + 1;
   localparam int CSR_DATA_W  = 16;
   localparam int SUM_W       = 12;
   localparam int CNT_W       = 4;
   localparam int NUM_W       = SUM_W + 1;
   localparam int RECIP_W     = 18;
   localparam int RECIP_SHIFT = 18;

   localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_W-1:0]    HEIGHT_RESET = 16'd480;

   localparam logic REQ_FLUSH = 1'b1;

   typedef enum logic {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } ebb_csr_type;

   typedef struct packed {
      logic              req_type;
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } ebb_req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
      logic              frame_end;
   } ebb_rsp_type;

   typedef struct packed {
      logic write;
      logic emit;
      logic skip_top;
      logic skip_bottom;
      logic skip_left;
      logic skip_right;
      logic last;
   } ebb_ctl_type;

   typedef struct packed {
      logic [2:0][NUM_W-1:0] num;
      logic [RECIP_W-1:0]    recip;
      logic                  last;
   } ebb_sum_type;

   // Multiplier for rounded division by twice the neighbor count.
   function automatic logic [RECIP_W-1:0] ebb_recip(input logic [CNT_W-1:0] count);
      logic [RECIP_W-1:0] r;
      case (count)
         4'd1: r = 18'd131072;
         4'd2: r = 18'd65536;
         4'd3: r = 18'd43691;
         4'd4: r = 18'd32768;
         4'd6: r = 18'd21846;
         4'd9: r = 18'd14564;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

[hdl/ebb_ram.sv]
`default_nettype none

module ebb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hdl/ebb_window.sv]
`default_nettype none

module ebb_window
   import ebb_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         en,
   input  wire logic                         issue_valid,
   input  wire logic [$clog2(MAX_WIDTH)-1:0] issue_col,
   input  wire ebb_ctl_type                  issue_ctl,
   input  wire logic [PIXEL_W-1:0]           issue_pixel,
   output logic                              sum_valid,
   output ebb_sum_type                       sum_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic               s1_valid_ff, s1_valid_in;
   ebb_ctl_type        s1_ctl_ff;
   logic [COL_W-1:0]   s1_col_ff;
   logic [PIXEL_W-1:0] s1_pixel_ff;
   logic               fwd_ff, fwd_in;
   logic [PIXEL_W-1:0] fwd_older_ff, fwd_newer_ff;

   logic [PIXEL_W-1:0] older_rd, newer_rd, older_eff, newer_eff;
   logic               rd_en, wr_en;

   logic [PIXEL_W-1:0] win_ff [3][3];

   logic               s2_valid_ff;
   ebb_ctl_type        s2_ctl_ff;
   logic               s3_valid_ff;
   ebb_sum_type        s3_data_ff, s3_data_in;

   assign rd_en = en && issue_valid;
   assign wr_en = en && s1_valid_ff && s1_ctl_ff.write;

   ebb_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) older_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_col_ff),
      .wr_data (newer_eff),
      .rd_en   (rd_en),
      .rd_addr (issue_col),
      .rd_data (older_rd)
   );

   ebb_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) newer_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_col_ff),
      .wr_data (s1_pixel_ff),
      .rd_en   (rd_en),
      .rd_addr (issue_col),
      .rd_data (newer_rd)
   );

   // A read issued while the previous item writes the same column takes the new data.
   assign fwd_in      = s1_valid_ff && s1_ctl_ff.write && (s1_col_ff == issue_col);
   assign older_eff   = fwd_ff ? fwd_older_ff : older_rd;
   assign newer_eff   = fwd_ff ? fwd_newer_ff : newer_rd;
   assign s1_valid_in = en ? issue_valid : s1_valid_ff;

   always_comb begin
      logic [SUM_W-1:0] sum_r, sum_g, sum_b;
      logic [CNT_W-1:0] count;
      logic             incl;
      sum_r = '0;
      sum_g = '0;
      sum_b = '0;
      count = '0;
      for (int k = 0; k < 3; k++) begin
         for (int j = 0; j < 3; j++) begin
            incl = !(k == 0 && s2_ctl_ff.skip_top) && !(k == 2 && s2_ctl_ff.skip_bottom) &&
                   !(j == 0 && s2_ctl_ff.skip_left) && !(j == 2 && s2_ctl_ff.skip_right);
            if (incl) begin
               sum_r = sum_r + SUM_W'(win_ff[k][j][23:16]);
               sum_g = sum_g + SUM_W'(win_ff[k][j][15:8]);
               sum_b = sum_b + SUM_W'(win_ff[k][j][7:0]);
               count = count + CNT_W'(1);
            end
         end
      end
      s3_data_in.num[2] = {sum_r, 1'b0} + NUM_W'(count);
      s3_data_in.num[1] = {sum_g, 1'b0} + NUM_W'(count);
      s3_data_in.num[0] = {sum_b, 1'b0} + NUM_W'(count);
      s3_data_in.recip  = ebb_recip(count);
      s3_data_in.last   = s2_ctl_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[k][j] <= '0;
            end
         end
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (rd_en) begin
            fwd_ff <= fwd_in;
         end
         if (en) begin
            s2_valid_ff <= s1_valid_ff && s1_ctl_ff.emit;
            s3_valid_ff <= s2_valid_ff;
            if (s1_valid_ff) begin
               for (int k = 0; k < 3; k++) begin
                  win_ff[k][0] <= win_ff[k][1];
                  win_ff[k][1] <= win_ff[k][2];
               end
               win_ff[0][2] <= older_eff;
               win_ff[1][2] <= newer_eff;
               win_ff[2][2] <= s1_pixel_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         fwd_older_ff <= newer_eff;
         fwd_newer_ff <= s1_pixel_ff;
      end
      if (en) begin
         s1_ctl_ff   <= issue_ctl;
         s1_col_ff   <= issue_col;
         s1_pixel_ff <= issue_pixel;
         s2_ctl_ff   <= s1_ctl_ff;
         s3_data_ff  <= s3_data_in;
      end
   end

   assign sum_valid = s3_valid_ff;
   assign sum_data  = s3_data_ff;

endmodule

`default_nettype wire

[hdl/ebb_divide.sv]
`default_nettype none

module ebb_divide
   import ebb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        sum_valid,
   input  wire ebb_sum_type sum_data,
   output logic             en,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output ebb_rsp_type      rsp_data
);

   localparam int PROD_W = NUM_W + RECIP_W;

   logic                  rsp_valid_ff, rsp_valid_in;
   ebb_rsp_type           rsp_data_ff, rsp_data_in;
   logic                  load;
   logic [2:0][PROD_W-1:0] prod;

   assign en   = !(sum_valid && rsp_valid_ff && !rsp_ready);
   assign load = sum_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         prod[c] = PROD_W'(sum_data.num[c]) * PROD_W'(sum_data.recip);
      end
      rsp_data_in.red_out   = prod[2][RECIP_SHIFT +: CHAN_W];
      rsp_data_in.green_out = prod[1][RECIP_SHIFT +: CHAN_W];
      rsp_data_in.blue_out  = prod[0][RECIP_SHIFT +: CHAN_W];
      rsp_data_in.frame_end = sum_data.last;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[hdl/edge_clipped_box_blur.sv]
// Accepts one item per cycle while the result side keeps up; a pixel's result passes
// window registers s1, s2, s3 and the divide output register once the item completing
// its neighborhood is taken. Both line buffer RAMs are read once per item and written
// once per in-frame item. Synchronous reset clears counters, window, pipeline valids
// and loads a 640x480 frame size; line buffers are not cleared and need not be.
`default_nettype none

module edge_clipped_box_blur
   import ebb_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire ebb_req_type           req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output ebb_rsp_type                rsp_data,
   input  wire logic                  csr_wr_en,
   input  wire ebb_csr_type           csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int EW    = ($clog2(MAX_WIDTH + 1) > WIDTH_REG_W) ?
                          $clog2(MAX_WIDTH + 1) : WIDTH_REG_W;

   logic [WIDTH_REG_W-1:0] width_ff, width_in;
   logic [HEIGHT_W-1:0]    height_ff, height_in;
   logic [IN_ROW_W-1:0]    in_row_ff, in_row_in;
   logic [COL_W-1:0]       in_col_ff, in_col_in;
   logic [HEIGHT_W-1:0]    out_row_ff, out_row_in;
   logic [COL_W-1:0]       out_col_ff, out_col_in;

   logic [EW-1:0]       w_raw, w_eff;
   logic [HEIGHT_W-1:0] h_eff;
   logic                in_frame, is_flush, take, adv, col_end;
   logic                en;
   ebb_ctl_type         ctl;
   logic [PIXEL_W-1:0]  pixel;
   logic                sum_valid;
   ebb_sum_type         sum_data;

   always_comb begin
      w_raw = EW'(width_ff);
      if (width_ff == '0) begin
         w_eff = EW'(1);
      end else if (w_raw > EW'(MAX_WIDTH)) begin
         w_eff = EW'(MAX_WIDTH);
      end else begin
         w_eff = w_raw;
      end
      h_eff = (height_ff == '0) ? HEIGHT_W'(1) : height_ff;

      in_frame = in_row_ff < IN_ROW_W'(h_eff);
      is_flush = req_data.req_type == REQ_FLUSH;
      take     = req_valid && req_ready;
      adv      = take && !(in_frame && is_flush);
      col_end  = (EW'(in_col_ff) + EW'(1)) >= w_eff;

      ctl.write       = in_frame;
      ctl.emit        = (in_row_ff >= IN_ROW_W'(2)) ||
                        (in_row_ff == IN_ROW_W'(1) && in_col_ff != '0);
      ctl.skip_top    = out_row_ff == '0;
      ctl.skip_bottom = (IN_ROW_W'(out_row_ff) + IN_ROW_W'(1)) >= IN_ROW_W'(h_eff);
      ctl.skip_left   = out_col_ff == '0;
      ctl.skip_right  = (EW'(out_col_ff) + EW'(1)) >= w_eff;
      ctl.last        = ctl.skip_bottom && ctl.skip_right;

      pixel = in_frame ? {req_data.red_in, req_data.green_in, req_data.blue_in} : '0;

      width_in   = width_ff;
      height_in  = height_ff;
      in_row_in  = in_row_ff;
      in_col_in  = in_col_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_wr_data[WIDTH_REG_W-1:0];
            CSR_IMAGE_HEIGHT: height_in = csr_wr_data[HEIGHT_W-1:0];
            default: ;
         endcase
         in_row_in  = '0;
         in_col_in  = '0;
         out_row_in = '0;
         out_col_in = '0;
      end else if (adv) begin
         if (col_end) begin
            in_col_in = '0;
            in_row_in = in_row_ff + IN_ROW_W'(1);
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
         if (ctl.emit) begin
            if (ctl.last) begin
               in_row_in  = '0;
               in_col_in  = '0;
               out_row_in = '0;
               out_col_in = '0;
            end else if (ctl.skip_right) begin
               out_col_in = '0;
               out_row_in = out_row_ff + HEIGHT_W'(1);
            end else begin
               out_col_in = out_col_ff + COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WIDTH_RESET;
         height_ff  <= HEIGHT_RESET;
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         in_row_ff  <= in_row_in;
         in_col_ff  <= in_col_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
      end
   end

   assign req_ready = en;

   ebb_window #(.MAX_WIDTH(MAX_WIDTH)) window (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .issue_valid (adv),
      .issue_col   (in_col_ff),
      .issue_ctl   (ctl),
      .issue_pixel (pixel),
      .sum_valid   (sum_valid),
      .sum_data    (sum_data)
   );

   ebb_divide divide (
      .clock     (clock),
      .reset     (reset),
      .sum_valid (sum_valid),
      .sum_data  (sum_data),
      .en        (en),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assert property (@(posedge clock) disable iff (reset)
      EW'(in_col_ff) < w_eff)
      else $error("Input column ran past the row width.");

   assert property (@(posedge clock) disable iff (reset)
      in_row_ff <= IN_ROW_W'(h_eff) + IN_ROW_W'(1))
      else $error("Input row ran past the end of the drain.");

   assert property (@(posedge clock) disable iff (reset)
      (in_row_ff == '0) |-> (out_row_ff == '0 && out_col_ff == '0))
      else $error("Output position moved ahead of the input lag.");

endmodule

`default_nettype wire

[test/edge_clipped_box_blur_tb.sv]
`timescale 1ns / 1ps

module edge_clipped_box_blur_tb;
   import ebb_pkg::*;

   localparam int MAX_COLS = 1024;
   localparam logic REQ_PIXEL = !REQ_FLUSH;
   localparam int RANDOM_ITEMS = 250;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   ebb_req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   ebb_rsp_type rsp_data;
   logic csr_wr_en;
   ebb_csr_type csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   edge_clipped_box_blur #(.MAX_WIDTH(MAX_COLS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   logic [PIXEL_W-1:0] older_row [MAX_COLS];
   logic [PIXEL_W-1:0] newer_row [MAX_COLS];
   logic [PIXEL_W-1:0] blur_window [3][3];
   int unsigned blur_cfg_width;
   int unsigned blur_cfg_height;
   int unsigned blur_in_row;
   int unsigned blur_in_col;
   int unsigned blur_out_row;
   int unsigned blur_out_col;

   ebb_rsp_type expected_pixels [$];
   bit frame_closed;
   bit send_gaps_on;
   bit recv_gaps_on = 1'b1;
   int rsp_hold_request;
   int blur_steps;
   int ignored_flushes;
   int frames_done;
   int results_checked;
   int error_count;

   function automatic int unsigned blur_width();
      if (blur_cfg_width == 0) return 1;
      if (blur_cfg_width > MAX_COLS) return MAX_COLS;
      return blur_cfg_width;
   endfunction

   function automatic int unsigned blur_height();
      return (blur_cfg_height == 0) ? 1 : blur_cfg_height;
   endfunction

   task automatic restart_blur_frame();
      blur_in_row = 0;
      blur_in_col = 0;
      blur_out_row = 0;
      blur_out_col = 0;
   endtask

   task automatic reset_blur_model();
      blur_cfg_width = 32'(WIDTH_RESET);
      blur_cfg_height = 32'(HEIGHT_RESET);
      for (int i = 0; i < MAX_COLS; i++) begin
         older_row[i] = '0;
         newer_row[i] = '0;
      end
      for (int k = 0; k < 3; k++) begin
         for (int j = 0; j < 3; j++) begin
            blur_window[k][j] = '0;
         end
      end
      restart_blur_frame();
   endtask

   task automatic predict_blur(input ebb_req_type item);
      int unsigned w;
      int unsigned h;
      int unsigned col;
      int unsigned count;
      int unsigned sum [3];
      longint unsigned pos;
      logic [PIXEL_W-1:0] px;
      ebb_rsp_type want;
      bit last;
      w = blur_width();
      h = blur_height();
      col = blur_in_col % MAX_COLS;
      if (blur_in_row < h && item.req_type == REQ_FLUSH) begin
         ignored_flushes++;
         return;
      end
      blur_steps++;
      for (int k = 0; k < 3; k++) begin
         blur_window[k][0] = blur_window[k][1];
         blur_window[k][1] = blur_window[k][2];
      end
      blur_window[0][2] = older_row[col];
      blur_window[1][2] = newer_row[col];
      if (blur_in_row < h) begin
         blur_window[2][2] = {item.red_in, item.green_in, item.blue_in};
         older_row[col] = newer_row[col];
         newer_row[col] = blur_window[2][2];
      end else begin
         blur_window[2][2] = '0;
      end
      pos = 64'(blur_in_row) * 64'(w) + 64'(blur_in_col);
      blur_in_col++;
      if (blur_in_col >= w) begin
         blur_in_col = 0;
         blur_in_row++;
      end
      if (pos < 64'(w) + 64'd1) return;
      count = 0;
      sum = '{0, 0, 0};
      for (int k = 0; k < 3; k++) begin
         for (int j = 0; j < 3; j++) begin
            if (k == 0 && blur_out_row == 0) continue;
            if (k == 2 && blur_out_row + 1 >= h) continue;
            if (j == 0 && blur_out_col == 0) continue;
            if (j == 2 && blur_out_col + 1 >= w) continue;
            px = blur_window[k][j];
            sum[0] += 32'(px[23:16]);
            sum[1] += 32'(px[15:8]);
            sum[2] += 32'(px[7:0]);
            count++;
         end
      end
      want.red_out = CHAN_W'((2 * sum[0] + count) / (2 * count));
      want.green_out = CHAN_W'((2 * sum[1] + count) / (2 * count));
      want.blue_out = CHAN_W'((2 * sum[2] + count) / (2 * count));
      last = (blur_out_row + 1 >= h) && (blur_out_col + 1 >= w);
      want.frame_end = last;
      expected_pixels.push_back(want);
      blur_out_col++;
      if (blur_out_col >= w) begin
         blur_out_col = 0;
         blur_out_row++;
      end
      if (last) begin
         restart_blur_frame();
         frame_closed = 1'b1;
         frames_done++;
      end
   endtask

   function automatic logic [CHAN_W-1:0] random_channel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return CHAN_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic ebb_req_type make_item(input logic kind, input logic [CHAN_W-1:0] r,
                                             input logic [CHAN_W-1:0] g,
                                             input logic [CHAN_W-1:0] b);
      ebb_req_type item;
      item.req_type = kind;
      item.red_in = r;
      item.green_in = g;
      item.blue_in = b;
      return item;
   endfunction

   function automatic ebb_req_type random_pixel();
      return make_item(REQ_PIXEL, random_channel(), random_channel(), random_channel());
   endfunction

   task automatic send_item(input ebb_req_type item);
      int gap;
      gap = send_gaps_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      predict_blur(item);
   endtask

   // Pixel items cause no result during the lag, so the pipeline may still be busy
   // after the last expected result; the extra cycles cover that.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic set_frame(input int raw_width, input int raw_height);
      logic [CSR_DATA_W-1:0] wdata;
      wdata = CSR_DATA_W'($urandom);
      wdata[WIDTH_REG_W-1:0] = WIDTH_REG_W'(raw_width);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wr_data <= wdata;
      @(posedge clock);
      blur_cfg_width = 32'(wdata[WIDTH_REG_W-1:0]);
      restart_blur_frame();
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wr_data <= CSR_DATA_W'(raw_height);
      @(posedge clock);
      blur_cfg_height = 32'(CSR_DATA_W'(raw_height));
      restart_blur_frame();
      csr_wr_en <= 1'b0;
      frame_closed = 1'b0;
   endtask

   task automatic stream_frame(input int early_flush_pct, input int drain_pixel_pct);
      ebb_req_type item;
      frame_closed = 1'b0;
      while (!frame_closed) begin
         item = random_pixel();
         if (blur_in_row < blur_height()) begin
            if ($urandom_range(1, 100) <= early_flush_pct) item.req_type = REQ_FLUSH;
         end else if ($urandom_range(1, 100) > drain_pixel_pct) begin
            item.req_type = REQ_FLUSH;
         end
         send_item(item);
      end
   endtask

   task automatic compare_field(input string field, input logic [CHAN_W-1:0] want,
                                input logic [CHAN_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         error_count++;
      end
   endtask

   task automatic check_result(input ebb_rsp_type got);
      ebb_rsp_type want;
      if (expected_pixels.size() == 0) begin
         $display("%0t: unexpected result transfer, expected none, actual %h", $time, got);
         error_count++;
      end else begin
         want = expected_pixels.pop_front();
         compare_field("red_out", want.red_out, got.red_out);
         compare_field("green_out", want.green_out, got.green_out);
         compare_field("blue_out", want.blue_out, got.blue_out);
         compare_field("frame_end", want.frame_end, got.frame_end);
         results_checked++;
      end
   endtask

   initial begin : result_sink
      int stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (rsp_hold_request > 0) begin
            stall = rsp_hold_request;
            rsp_hold_request = 0;
         end else begin
            stall = recv_gaps_on ? $urandom_range(0, 5) : 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         check_result(rsp_data);
      end
   end

   task automatic test_reset_size();
      send_gaps_on = 1'b0;
      send_item(make_item(REQ_FLUSH, 8'hff, 8'hff, 8'hff));
      send_item(make_item(REQ_FLUSH, 8'h00, 8'h00, 8'h00));
      repeat (645) send_item(random_pixel());
      wait_drained();
   endtask

   task automatic test_edge_cases();
      send_gaps_on = 1'b1;
      set_frame(0, 0);
      send_item(make_item(REQ_PIXEL, 8'hff, 8'h00, 8'hff));
      while (!frame_closed) send_item(make_item(REQ_FLUSH, 8'h00, 8'hff, 8'h00));
      wait_drained();
      set_frame(3, 3);
      for (int i = 0; i < 9; i++) begin
         send_item(make_item(REQ_PIXEL, (i % 2) ? 8'hff : 8'h00, (i % 2) ? 8'h00 : 8'hff,
                             (i < 4) ? 8'hff : 8'h00));
         if (i == 4) send_item(make_item(REQ_FLUSH, 8'hff, 8'hff, 8'hff));
      end
      send_item(make_item(REQ_PIXEL, 8'h80, 8'h7f, 8'h01));
      while (!frame_closed) send_item(make_item(REQ_FLUSH, 8'h00, 8'h00, 8'h00));
      wait_drained();
      set_frame(3, 1);
      send_item(make_item(REQ_PIXEL, 8'hff, 8'hff, 8'hff));
      send_item(make_item(REQ_PIXEL, 8'h00, 8'h00, 8'h00));
      send_item(make_item(REQ_PIXEL, 8'hff, 8'h01, 8'hfe));
      while (!frame_closed) send_item(make_item(REQ_FLUSH, 8'haa, 8'h55, 8'hff));
      wait_drained();
   endtask

   task automatic test_config_restart();
      send_gaps_on = 1'b1;
      set_frame(5, 4);
      repeat (13) send_item(random_pixel());
      wait_drained();
      set_frame(4, 3);
      stream_frame(0, 0);
      wait_drained();
   endtask

   task automatic test_size_extremes();
      send_gaps_on = 1'b0;
      recv_gaps_on = 1'b0;
      set_frame(2, 65535);
      repeat (50) send_item(random_pixel());
      wait_drained();
      set_frame(2047, 1);
      repeat (MAX_COLS + 6) send_item(random_pixel());
      wait_drained();
   endtask

   task automatic test_backpressure();
      send_gaps_on = 1'b0;
      recv_gaps_on = 1'b1;
      set_frame(10, 6);
      rsp_hold_request = 400;
      stream_frame(0, 0);
      wait_drained();
   endtask

   task automatic test_random_frames();
      int start;
      int w;
      int h;
      int abort_at;
      bit reconfigure;
      start = blur_steps;
      reconfigure = 1'b1;
      while (blur_steps - start < RANDOM_ITEMS) begin
         send_gaps_on = $urandom_range(0, 3) != 0;
         recv_gaps_on = $urandom_range(0, 3) != 0;
         if (reconfigure || $urandom_range(0, 1)) begin
            case ($urandom_range(0, 19)) inside
               [0:13]: w = $urandom_range(1, 8);
               [14:18]: w = $urandom_range(9, 40);
               default: w = $urandom_range(41, 120);
            endcase
            if ($urandom_range(0, 24) == 0) w = 0;
            h = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
            if ($urandom_range(0, 24) == 0) h = 0;
            if (w > 40) h = $urandom_range(1, 3);
            wait_drained();
            set_frame(w, h);
         end
         reconfigure = 1'b0;
         if ($urandom_range(0, 9) == 0) begin
            abort_at = $urandom_range(1, blur_width() * blur_height());
            repeat (abort_at) send_item(random_pixel());
            reconfigure = 1'b1;
         end else begin
            stream_frame(5, 15);
         end
      end
      wait_drained();
   endtask

   initial begin
      reset_blur_model();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wr_data <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_size();
      test_edge_cases();
      test_config_restart();
      test_size_extremes();
      test_backpressure();
      test_random_frames();
      $display("Covered %0d finished frames, %0d checked results and %0d dropped flushes.",
               frames_done, results_checked, ignored_flushes);
      $display("Sizes ran from 1x1 to a clamped full width, with restarts and long stalls.");
      if (error_count == 0 && expected_pixels.size() == 0) begin
         $display("PASS edge_clipped_box_blur");
      end else begin
         $display("FAIL edge_clipped_box_blur");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL edge_clipped_box_blur");
      $finish;
   end

endmodule
